FILE: design/assert_macros.svh
// Assertion macros for the checker file of the timer core.
// No dependencies; take it in by `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/mcdt_pkg.sv
// Package of the multi-channel deadline timer: sizes, op codes, FSM states
// and the armed-mask helper. No dependencies.
`default_nettype none

package mcdt_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MASK_W    = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int TIME_W    = 32;
  localparam int VALUE_W   = 31;
  localparam int ID_W      = 3;
  localparam int OP_W      = 2;
  localparam int AMASK_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PERIOD = 2'd0,
    OP_ARM        = 2'd1,
    OP_DISARM     = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_PEND,
    ST_SEL,
    ST_TIE,
    ST_EXP
  } state_t;

  // Armed bits of slots 0..7 only; higher slots never show in the mask.
  function automatic logic [AMASK_W-1:0] mask8(input logic [NUM_SLOTS-1:0] a);
    logic [AMASK_W-1:0] m;
    m = '0;
    m[MASK_W-1:0] = a[MASK_W-1:0];
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: design/multi_channel_deadline_timer_core.sv
// Top level of the multi-channel deadline timer core.
// Depends on mcdt_pkg (sizes, op codes, states, mask helper).
`default_nettype none

// Multi-channel deadline timer. NUM_SLOTS timer slots (period, deadline,
// armed flag, arming sequence number) share a 32-bit free-running time
// counter. Op 0 sets a period (0 = one-shot), op 1 arms a slot at
// now + value (re-arming drops the old deadline), op 2 disarms, op 3 is a
// tick: time advances by one and every armed slot whose deadline is reached
// is reported, one beat per slot, earliest deadline first, ties broken by
// arming order; all compares are wrap-aware (a before b when bit 31 of a-b
// is set). Periodic slots re-arm at now + period, one-shot slots disarm.
// A tick with nothing expired still gives one beat with expired_valid low;
// ops 0 to 2 give exactly one beat. Every beat carries the armed mask after
// the whole op, and out_last marks the final beat of an input.
// Sequence: ops 0 to 2 are taken while idle and applied in the exec step. A
// tick is taken, advances time in the tick step, marks the expired slots in
// one pass over all NUM_SLOTS slots, then per expired slot runs one full scan
// of the NUM_SLOTS slots (plus a tie step per deadline tie) and one update
// step. With nothing expired the tick still runs one empty scan. A stalled
// out_ready stretches each update step until the output register frees.
// This sequencing is set by the single shared 32-bit add/subtract unit, which
// looks at one slot per cycle. in_ready is high only while idle; the output
// register lets the last beat of an item wait while the next item is taken.
// Slot storage is flip-flops; there is no clearing pass after reset.
module multi_channel_deadline_timer_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [mcdt_pkg::OP_W-1:0]    in_op,
  input  wire logic [mcdt_pkg::ID_W-1:0]    in_timer_id,
  input  wire logic [mcdt_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_expired_valid,
  output logic [mcdt_pkg::ID_W-1:0]         out_expired_id,
  output logic                              out_is_armed,
  output logic [mcdt_pkg::AMASK_W-1:0]      out_armed_mask,
  output logic                              out_last
);
  import mcdt_pkg::*;

  // control state
  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]    seq_r, seq_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  logic [VALUE_W-1:0]   period_r [NUM_SLOTS];
  logic [VALUE_W-1:0]   period_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt;
  logic                 found_r, found_nxt;
  logic                 emitted_r, emitted_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload state (slot stores are undefined until armed)
  logic [TIME_W-1:0]    dl_r [NUM_SLOTS];
  logic [TIME_W-1:0]    dl_nxt [NUM_SLOTS];
  logic [TIME_W-1:0]    ord_r [NUM_SLOTS];
  logic [TIME_W-1:0]    ord_nxt [NUM_SLOTS];
  op_t                  op_r, op_nxt;
  logic [SLOT_W-1:0]    id_r, id_nxt;
  logic                 id_ok_r, id_ok_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SLOT_W-1:0]    best_r, best_nxt;
  logic [TIME_W-1:0]    best_dl_r, best_dl_nxt;
  logic [TIME_W-1:0]    best_ord_r, best_ord_nxt;
  logic [AMASK_W-1:0]   fin_mask_r, fin_mask_nxt;
  logic                 oexp_r, oexp_nxt;
  logic [ID_W-1:0]      oid_r, oid_nxt;
  logic                 oarm_r, oarm_nxt;
  logic [AMASK_W-1:0]   omask_r, omask_nxt;
  logic                 olast_r, olast_nxt;

  // shared add/subtract unit
  logic [TIME_W-1:0]    alu_a, alu_b, alu_res;
  logic                 alu_sub;
  logic                 alu_neg;

  logic                 in_fire;
  logic                 out_free;
  logic                 idx_last;
  logic                 dl_eq;
  logic                 sel_take;
  logic                 sel_tie;
  logic                 found_after;
  logic [NUM_SLOTS-1:0] zper;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_last  = (idx_r == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      zper[i] = (period_r[i] == '0);
    end
  end

  // operand select per sequencer step
  always_comb begin
    alu_a   = now_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        alu_b = {1'b0, value_r};
      end
      ST_TICK: begin
        alu_b = TIME_W'(1);
      end
      ST_PEND: begin
        alu_b   = dl_r[idx_r];
        alu_sub = 1'b1;
      end
      ST_SEL: begin
        alu_a   = dl_r[idx_r];
        alu_b   = best_dl_r;
        alu_sub = 1'b1;
      end
      ST_TIE: begin
        alu_a   = ord_r[idx_r];
        alu_b   = best_ord_r;
        alu_sub = 1'b1;
      end
      ST_EXP: begin
        alu_b = {1'b0, period_r[best_r]};
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);
  assign alu_neg = alu_res[TIME_W-1];

  // scan step: candidate beats best when none is found yet or its deadline is strictly before
  assign dl_eq       = (dl_r[idx_r] == best_dl_r);
  assign sel_take    = pend_r[idx_r] && (!found_r || alu_neg);
  assign sel_tie     = pend_r[idx_r] && found_r && dl_eq;
  assign found_after = found_r || pend_r[idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (op_t'(in_op) == OP_TICK) ? ST_TICK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        state_nxt = ST_PEND;
      end
      ST_PEND: begin
        if (idx_last) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        priority if (sel_tie) begin
          state_nxt = ST_TIE;
        end else if (idx_last && found_after) begin
          state_nxt = ST_EXP;
        end else if (idx_last && (emitted_r || out_free)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TIE: begin
        state_nxt = idx_last ? ST_EXP : ST_SEL;
      end
      ST_EXP: begin
        if (out_free) begin
          state_nxt = (pend_nxt == '0) ? ST_IDLE : ST_SEL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and output register
  always_comb begin
    now_nxt      = now_r;
    seq_nxt      = seq_r;
    armed_nxt    = armed_r;
    period_nxt   = period_r;
    pend_nxt     = pend_r;
    found_nxt    = found_r;
    emitted_nxt  = emitted_r;
    dl_nxt       = dl_r;
    ord_nxt      = ord_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    id_ok_nxt    = id_ok_r;
    value_nxt    = value_r;
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    best_dl_nxt  = best_dl_r;
    best_ord_nxt = best_ord_r;
    fin_mask_nxt = fin_mask_r;
    out_valid_nxt = out_valid_r && !out_ready;
    oexp_nxt     = oexp_r;
    oid_nxt      = oid_r;
    oarm_nxt     = oarm_r;
    omask_nxt    = omask_r;
    olast_nxt    = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = op_t'(in_op);
          id_nxt    = SLOT_W'(in_timer_id);
          id_ok_nxt = (32'(in_timer_id) < NUM_SLOTS);
          value_nxt = in_value;
          idx_nxt   = '0;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (id_ok_r) begin
            unique case (op_r)
              OP_SET_PERIOD: period_nxt[id_r] = value_r;
              OP_ARM: begin
                dl_nxt[id_r]    = alu_res;
                ord_nxt[id_r]   = seq_r;
                seq_nxt         = seq_r + 1'b1;
                armed_nxt[id_r] = 1'b1;
              end
              OP_DISARM: armed_nxt[id_r] = 1'b0;
              default: begin
                armed_nxt = armed_r;
              end
            endcase
          end
          out_valid_nxt = 1'b1;
          oexp_nxt      = 1'b0;
          oid_nxt       = '0;
          oarm_nxt      = id_ok_r && armed_nxt[id_r];
          omask_nxt     = mask8(armed_nxt);
          olast_nxt     = 1'b1;
        end
      end
      ST_TICK: begin
        now_nxt     = alu_res;
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        emitted_nxt = 1'b0;
      end
      ST_PEND: begin
        // reached when now is not before the deadline
        pend_nxt[idx_r] = armed_r[idx_r] && !alu_neg;
        fin_mask_nxt    = mask8(armed_r & ~(pend_nxt & zper));
        idx_nxt         = idx_last ? '0 : idx_r + 1'b1;
      end
      ST_SEL: begin
        if (sel_take) begin
          best_nxt     = idx_r;
          best_dl_nxt  = dl_r[idx_r];
          best_ord_nxt = ord_r[idx_r];
          found_nxt    = 1'b1;
        end
        if (!sel_tie) begin
          if (!idx_last) begin
            idx_nxt = idx_r + 1'b1;
          end else if (found_after) begin
            idx_nxt = '0;
          end else if (!emitted_r && out_free) begin
            // tick with nothing expired
            out_valid_nxt = 1'b1;
            oexp_nxt      = 1'b0;
            oid_nxt       = '0;
            oarm_nxt      = 1'b0;
            omask_nxt     = fin_mask_r;
            olast_nxt     = 1'b1;
            idx_nxt       = '0;
          end
        end
      end
      ST_TIE: begin
        if (alu_neg) begin
          best_nxt     = idx_r;
          best_dl_nxt  = dl_r[idx_r];
          best_ord_nxt = ord_r[idx_r];
        end
        idx_nxt = idx_last ? '0 : idx_r + 1'b1;
      end
      ST_EXP: begin
        if (out_free) begin
          pend_nxt[best_r] = 1'b0;
          if (!zper[best_r]) begin
            dl_nxt[best_r]  = alu_res;
            ord_nxt[best_r] = seq_r;
            seq_nxt         = seq_r + 1'b1;
          end else begin
            armed_nxt[best_r] = 1'b0;
          end
          out_valid_nxt = 1'b1;
          oexp_nxt      = 1'b1;
          oid_nxt       = ID_W'(best_r);
          oarm_nxt      = !zper[best_r];
          omask_nxt     = fin_mask_r;
          olast_nxt     = (pend_nxt == '0);
          emitted_nxt   = 1'b1;
          found_nxt     = 1'b0;
          idx_nxt       = '0;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      seq_r       <= '0;
      armed_r     <= '0;
      pend_r      <= '0;
      found_r     <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      seq_r       <= seq_nxt;
      armed_r     <= armed_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
      period_r    <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r       <= dl_nxt;
    ord_r      <= ord_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    id_ok_r    <= id_ok_nxt;
    value_r    <= value_nxt;
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    best_ord_r <= best_ord_nxt;
    fin_mask_r <= fin_mask_nxt;
    oexp_r     <= oexp_nxt;
    oid_r      <= oid_nxt;
    oarm_r     <= oarm_nxt;
    omask_r    <= omask_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_expired_valid = oexp_r;
  assign out_expired_id    = oid_r;
  assign out_is_armed      = oarm_r;
  assign out_armed_mask    = omask_r;
  assign out_last          = olast_r;

endmodule

`default_nettype wire

FILE: design/mcdt_checker.sv
// Port-level checker for the timer core, bound to the top level below.
// Depends on mcdt_pkg (port widths) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcdt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_expired_valid,
  input wire logic [mcdt_pkg::ID_W-1:0]    out_expired_id,
  input wire logic                         out_is_armed,
  input wire logic [mcdt_pkg::AMASK_W-1:0] out_armed_mask,
  input wire logic                         out_last
);

  // a beat held back stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // an accepted input makes the core busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a beat without an expired slot is always the only one of its input
  `ASSERT_IMPLY(a_plain_last, clk, rst_n, out_valid && !out_expired_valid,
                out_last && (out_expired_id == '0))
  // the expired slot's armed bit matches its bit of the final mask
  `ASSERT_IMPLY(a_mask_agrees, clk, rst_n, out_valid && out_expired_valid,
                out_armed_mask[out_expired_id] == out_is_armed)

endmodule

bind multi_channel_deadline_timer_core mcdt_checker u_mcdt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_expired_valid (out_expired_valid),
  .out_expired_id    (out_expired_id),
  .out_is_armed      (out_is_armed),
  .out_armed_mask    (out_armed_mask),
  .out_last          (out_last)
);

`default_nettype wire

FILE: test/tb_multi_channel_deadline_timer_core.sv
`timescale 1ns / 1ps
// Testbench of multi_channel_deadline_timer_core: directed and random timer ops,
// each output beat checked against an in-bench model of the slots and time counter.
// Depends on mcdt_pkg (sizes, op codes) and the core itself.
module tb_multi_channel_deadline_timer_core;
  import mcdt_pkg::*;

  // Wrap-aware compare: a is before b when (a - b) lies above this.
  localparam logic [TIME_W-1:0] HALF_SPAN = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7fff_ffff;

  // One output beat as the model predicts it.
  typedef struct packed {
    logic               expired_valid;
    logic [ID_W-1:0]    expired_id;
    logic               is_armed;
    logic [AMASK_W-1:0] armed_mask;
    logic               last;
  } timer_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_op = '0;
  logic [ID_W-1:0]    in_timer_id = '0;
  logic [VALUE_W-1:0] in_value = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_expired_valid;
  logic [ID_W-1:0]    out_expired_id;
  logic               out_is_armed;
  logic [AMASK_W-1:0] out_armed_mask;
  logic               out_last;

  int unsigned in_idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned out_idle_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned hold_left = 0;     // cycles left in a forced receiver stall
  int unsigned err_count = 0;

  // Beats still owed by the core, oldest first.
  timer_beat_t owed_beats[$];

  // Model state: time counter, per-slot deadline/period/armed/arm order.
  logic [TIME_W-1:0]    model_now;
  logic [TIME_W-1:0]    model_deadline [NUM_SLOTS];
  logic [VALUE_W-1:0]   model_period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] model_armed;
  logic [TIME_W-1:0]    model_order [NUM_SLOTS];
  logic [TIME_W-1:0]    model_seq;

  multi_channel_deadline_timer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_timer_id       (in_timer_id),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_expired_valid (out_expired_valid),
    .out_expired_id    (out_expired_id),
    .out_is_armed      (out_is_armed),
    .out_armed_mask    (out_armed_mask),
    .out_last          (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the core hangs or drops a beat.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Timer model
  // ---------------------------------------------------------------------------

  function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d > HALF_SPAN;
  endfunction

  task automatic clear_model();
    int s;
    model_now = '0;
    model_seq = '0;
    model_armed = '0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      model_deadline[s] = '0;
      model_period[s] = '0;
      model_order[s] = '0;
    end
  endtask

  // Every arming, including a periodic re-arm on tick, takes a new sequence number.
  task automatic arm_model_slot(input int s, input logic [VALUE_W-1:0] delay);
    model_deadline[s] = model_now + {1'b0, delay};
    model_order[s] = model_seq;
    model_seq = model_seq + 1;
    model_armed[s] = 1'b1;
  endtask

  // Apply one accepted op to the model and queue the beats it should produce.
  task automatic model_timer_op(input op_t op, input logic [ID_W-1:0] id,
                                input logic [VALUE_W-1:0] value);
    timer_beat_t          b;
    logic [NUM_SLOTS-1:0] due;
    int                   order [NUM_SLOTS];
    int                   count;
    int                   best;
    int                   s;
    b = '0;
    if (op != OP_TICK) begin
      if (int'(id) < NUM_SLOTS) begin
        case (op)
          OP_SET_PERIOD: model_period[id] = value;
          OP_ARM:        arm_model_slot(int'(id), value);
          default:       model_armed[id] = 1'b0;
        endcase
        b.is_armed = model_armed[id];
      end
      b.armed_mask = model_armed;
      b.last = 1'b1;
      owed_beats.push_back(b);
      return;
    end

    // Tick: advance time, then drain due slots earliest deadline first,
    // ties by arming order.
    model_now = model_now + 1;
    for (s = 0; s < NUM_SLOTS; s++)
      due[s] = model_armed[s] && !earlier(model_now, model_deadline[s]);
    count = 0;
    while (due != '0) begin
      best = -1;
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (due[s]) begin
          if (best < 0)
            best = s;
          else if (earlier(model_deadline[s], model_deadline[best]) ||
                   (model_deadline[s] == model_deadline[best] &&
                    earlier(model_order[s], model_order[best])))
            best = s;
        end
      end
      due[best] = 1'b0;
      if (model_period[best] != '0)
        arm_model_slot(best, model_period[best]);
      else
        model_armed[best] = 1'b0;
      order[count] = best;
      count++;
    end

    if (count == 0) begin
      b.armed_mask = model_armed;
      b.last = 1'b1;
      owed_beats.push_back(b);
      return;
    end
    for (s = 0; s < count; s++) begin
      b.expired_valid = 1'b1;
      b.expired_id = order[s][ID_W-1:0];
      b.is_armed = model_armed[order[s]];
      b.armed_mask = model_armed;
      b.last = (s == count - 1);
      owed_beats.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Offer one beat and wait for the handshake. in_valid stays high on return,
  // so the next call can put a new payload on the very next edge.
  task automatic send_op(input op_t op, input logic [ID_W-1:0] id,
                         input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_timer_id <= id;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_timer_op(op, id, value);
  endtask

  // Mostly short delays so slots keep expiring; some zeros and full-width values.
  function automatic logic [VALUE_W-1:0] pick_value();
    int          r;
    logic [31:0] w;
    r = $urandom_range(99);
    if (r < 10)
      w = 0;
    else if (r < 80)
      w = $urandom_range(12, 1);
    else
      w = $urandom;
    return w[VALUE_W-1:0];
  endfunction

  task automatic send_random_op();
    int          r;
    logic [31:0] id_w;
    op_t         op;
    r = $urandom_range(99);
    id_w = $urandom_range(NUM_SLOTS - 1);
    if (r < 35)
      op = OP_TICK;
    else if (r < 50)
      op = OP_SET_PERIOD;
    else if (r < 85)
      op = OP_ARM;
    else
      op = OP_DISARM;
    send_op(op, id_w[ID_W-1:0], pick_value());
  endtask

  // Receiver: check each accepted beat against the oldest owed one, then
  // decide ready for the next edge.
  always @(posedge clk) begin : receive_beats
    timer_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_beats.size() == 0) begin
        report_mismatch("beat with none owed, expired_id", out_expired_id, 0);
      end else begin
        want = owed_beats.pop_front();
        if (out_expired_valid !== want.expired_valid)
          report_mismatch("expired_valid", out_expired_valid, want.expired_valid);
        if (out_expired_id !== want.expired_id)
          report_mismatch("expired_id", out_expired_id, want.expired_id);
        if (out_is_armed !== want.is_armed)
          report_mismatch("is_armed", out_is_armed, want.is_armed);
        if (out_armed_mask !== want.armed_mask)
          report_mismatch("armed_mask", out_armed_mask, want.armed_mask);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
  end

  // Forced receiver stall, counted down one cycle at a time.
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing armed: a tick still gives a single empty beat.
  task automatic test_empty_tick();
    send_op(OP_TICK, 3'd7, VALUE_MAX);
  endtask

  // Largest period on slot 0, zero on slot 7, and the largest delay.
  task automatic test_period_extremes();
    send_op(OP_SET_PERIOD, 3'd0, VALUE_MAX);
    send_op(OP_SET_PERIOD, 3'd7, '0);
    send_op(OP_ARM, 3'd0, VALUE_MAX);
  endtask

  // Re-arming drops the old deadline; the new short one fires.
  task automatic test_rearm();
    send_op(OP_ARM, 3'd4, 31'd5);
    send_op(OP_ARM, 3'd4, 31'd1);
    send_op(OP_TICK, 3'd0, '0);
  endtask

  task automatic test_disarm();
    send_op(OP_ARM, 3'd2, 31'd1);
    send_op(OP_DISARM, 3'd2, '0);
    send_op(OP_TICK, 3'd0, '0);
  endtask

  // Same deadline: slot 6 was armed first, so it comes out ahead of slot 1.
  task automatic test_tie_order();
    send_op(OP_ARM, 3'd6, 31'd1);
    send_op(OP_ARM, 3'd1, 31'd1);
    send_op(OP_TICK, 3'd3, '0);
  endtask

  // Period changed while armed: deadline kept, new period used on re-arm.
  task automatic test_period_change();
    send_op(OP_SET_PERIOD, 3'd5, 31'd2);
    send_op(OP_ARM, 3'd5, 31'd1);
    send_op(OP_SET_PERIOD, 3'd5, 31'd3);
    send_op(OP_TICK, 3'd0, '0);
  endtask

  // All slots at delay zero, armed high id first: one tick, eight beats,
  // order set purely by arming sequence.
  task automatic test_all_slots_due();
    int s;
    for (s = NUM_SLOTS - 1; s >= 0; s--)
      send_op(OP_ARM, s[ID_W-1:0], '0);
    send_op(OP_TICK, 3'd0, '0);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering,
  // so the core backs up and drops in_ready.
  task automatic test_backpressure();
    int k;
    in_idle_pct = 0;
    hold_left <= 400;
    for (k = 0; k < 12; k++)
      send_random_op();
  endtask

  task automatic test_random(input int n, input int unsigned in_pct, input int unsigned out_pct);
    int k;
    in_idle_pct = in_pct;
    out_idle_pct <= out_pct;
    for (k = 0; k < n; k++)
      send_random_op();
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 19;
    out_idle_pct <= 68;
    test_empty_tick();
    test_period_extremes();
    test_rearm();
    test_disarm();
    test_tie_order();
    test_period_change();
    test_all_slots_due();

    test_random(70, 19, 68);
    test_backpressure();
    test_random(70, 68, 19);
    test_random(50, 0, 0);
    in_valid <= 1'b0;

    // Drain, then keep the clock running for stray beats.
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (err_count == 0 && owed_beats.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: multi_channel_deadline_timer_core.f
+incdir+design
design/mcdt_pkg.sv
design/multi_channel_deadline_timer_core.sv
design/mcdt_checker.sv
test/tb_multi_channel_deadline_timer_core.sv
